### hdl/tfs_pkg.sv
// Shared types, constants and byte helpers for the rectangle fill streamer.
`default_nettype none

package tfs_pkg;

  // Panel and geometry widths
  localparam int CoordW    = 10;
  localparam int PixCountW = 2 * CoordW;
  localparam int ColorW    = 16;

  // Pixels per chip-select transfer in the pixel stream
  localparam int ChunkPixels = 64;
  localparam int ChunkW      = $clog2(ChunkPixels + 1);

  // Header: CASET + 4, PASET + 4, RAMWR
  localparam int HeaderLen = 11;
  localparam int HdrIdxW   = 4;

  // Command queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Configuration port
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 10;

  // DCS command codes
  localparam logic [7:0] CmdColAddrSet  = 8'h2A;
  localparam logic [7:0] CmdPageAddrSet = 8'h2B;
  localparam logic [7:0] CmdMemWrite    = 8'h2C;

  // 18-bit mode top-justification masks
  localparam logic [7:0] Mask5 = 8'hF8;
  localparam logic [7:0] Mask6 = 8'hFC;

  typedef enum logic [CfgAddrW-1:0] {
    CfgPanelWidth  = 2'd0,
    CfgPanelHeight = 2'd1,
    CfgPixelFormat = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } opcode_e;

  typedef enum logic {
    FmtRgb565 = 1'b0,
    FmtRgb666 = 1'b1
  } pix_fmt_e;

  // One queued command: a clipped fill window or an advance
  typedef struct packed {
    logic                 is_start;
    logic [CoordW-1:0]    col_first;
    logic [CoordW-1:0]    col_last;
    logic [CoordW-1:0]    row_first;
    logic [CoordW-1:0]    row_last;
    logic [ColorW-1:0]    color;
    logic [PixCountW-1:0] pixels;
  } fill_cmd_t;

  // Queue status/control between front and back
  typedef struct packed {
    logic      push;
    fill_cmd_t data;
  } q_wr_t;

  typedef struct packed {
    logic      empty;
    fill_cmd_t data;
  } q_rd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_cmd;
    logic       eot;
  } hdr_beat_t;

  function automatic hdr_beat_t header_beat(
    input logic [HdrIdxW-1:0] idx,
    input logic [CoordW-1:0]  cf,
    input logic [CoordW-1:0]  cl,
    input logic [CoordW-1:0]  rf,
    input logic [CoordW-1:0]  rl
  );
    hdr_beat_t hb;
    hb.is_cmd = 1'b0;
    hb.eot    = 1'b0;
    unique case (idx)
      4'd0: begin
        hb.data = CmdColAddrSet;
        hb.is_cmd = 1'b1;
        hb.eot = 1'b1;
      end
      4'd1: hb.data = 8'(cf >> 8);
      4'd2: hb.data = cf[7:0];
      4'd3: hb.data = 8'(cl >> 8);
      4'd4: begin
        hb.data = cl[7:0];
        hb.eot = 1'b1;
      end
      4'd5: begin
        hb.data = CmdPageAddrSet;
        hb.is_cmd = 1'b1;
        hb.eot = 1'b1;
      end
      4'd6: hb.data = 8'(rf >> 8);
      4'd7: hb.data = rf[7:0];
      4'd8: hb.data = 8'(rl >> 8);
      4'd9: begin
        hb.data = rl[7:0];
        hb.eot = 1'b1;
      end
      default: begin
        hb.data = CmdMemWrite;
        hb.is_cmd = 1'b1;
        hb.eot = 1'b1;
      end
    endcase
    return hb;
  endfunction

  function automatic logic [7:0] pixel_byte(
    input logic [ColorW-1:0] c,
    input pix_fmt_e          fmt,
    input logic [1:0]        bip
  );
    logic [7:0] b;
    if (fmt == FmtRgb565) begin
      b = (bip == 2'd0) ? c[15:8] : c[7:0];
    end else if (bip == 2'd0) begin
      b = c[15:8] & Mask5;
    end else if (bip == 2'd1) begin
      b = c[10:3] & Mask6;
    end else begin
      b = {c[4:0], 3'b000};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/tfs_if.sv
// Channel interfaces: fill commands in, SPI byte beats out, register writes.
`default_nettype none

interface tfs_cmd_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic        [15:0] fill_color;

  modport source (output valid, opcode, rect_x, rect_y, rect_w, rect_h, fill_color,
                  input ready);
  modport sink   (input valid, opcode, rect_x, rect_y, rect_w, rect_h, fill_color,
                  output ready);
endinterface

interface tfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       end_of_transfer;
  logic       last;

  modport source (output valid, out_byte, is_command, end_of_transfer, last,
                  input ready);
  modport sink   (input valid, out_byte, is_command, end_of_transfer, last,
                  output ready);
endinterface

interface tfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [9:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### hdl/tfs_front.sv
// Front end: accept commands, clip fill windows, drop no-ops, feed the queue.
`default_nettype none

module tfs_front
  import tfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tfs_cmd_if.sink                cmd_i,
  input  wire logic [CoordW-1:0] panel_width_i,
  input  wire logic [CoordW-1:0] panel_height_i,
  input  wire logic              q_full_i,
  output q_wr_t                  q_wr_o
);

  logic              s1_valid_q, s1_valid_d;
  logic              s1_start_q;
  logic [CoordW-1:0] s1_cf_q, s1_cl_q, s1_rf_q, s1_rl_q;
  logic [CoordW-1:0] s1_w_q, s1_h_q;
  logic [ColorW-1:0] s1_color_q;

  logic              accept;
  logic              keep;
  logic signed [17:0] x, y, w, h, pw, ph;

  // Clip the rectangle to the panel; empty or off-panel fills are dropped here
  always_comb begin
    x    = 18'(cmd_i.rect_x);
    y    = 18'(cmd_i.rect_y);
    w    = 18'(cmd_i.rect_w);
    h    = 18'(cmd_i.rect_h);
    pw   = $signed({8'b0, panel_width_i});
    ph   = $signed({8'b0, panel_height_i});
    keep = 1'b1;
    if (w <= 0 || h <= 0) keep = 1'b0;
    if (x >= pw || y >= ph) keep = 1'b0;
    if (x < 0) begin
      w = w + x;
      x = '0;
    end
    if (y < 0) begin
      h = h + y;
      y = '0;
    end
    if (x + w > pw) w = pw - x;
    if (y + h > ph) h = ph - y;
    if (w <= 0 || h <= 0) keep = 1'b0;
    if (opcode_e'(cmd_i.opcode) == OpAdvance) keep = 1'b1;
  end

  assign cmd_i.ready = !s1_valid_q || !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign q_wr_o.push           = s1_valid_q && !q_full_i;
  assign q_wr_o.data.is_start  = s1_start_q;
  assign q_wr_o.data.col_first = s1_cf_q;
  assign q_wr_o.data.col_last  = s1_cl_q;
  assign q_wr_o.data.row_first = s1_rf_q;
  assign q_wr_o.data.row_last  = s1_rl_q;
  assign q_wr_o.data.color     = s1_color_q;
  assign q_wr_o.data.pixels    = PixCountW'(s1_w_q) * PixCountW'(s1_h_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (q_wr_o.push) s1_valid_d = 1'b0;
    if (accept && keep) s1_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      s1_start_q <= (opcode_e'(cmd_i.opcode) == OpStart);
      s1_cf_q    <= x[CoordW-1:0];
      s1_cl_q    <= CoordW'(x + w - 18'sd1);
      s1_rf_q    <= y[CoordW-1:0];
      s1_rl_q    <= CoordW'(y + h - 18'sd1);
      s1_w_q     <= w[CoordW-1:0];
      s1_h_q     <= h[CoordW-1:0];
      s1_color_q <= cmd_i.fill_color;
    end
  end

endmodule

`default_nettype wire

### hdl/tfs_fifo.sv
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module tfs_fifo
  import tfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  q_wr_t     wr_i,
  output logic      full_o,
  input  wire logic pop_i,
  output q_rd_t     rd_o
);

  fill_cmd_t         mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   count_q, count_d;
  logic              do_pop;

  assign full_o     = (count_q == (FifoAw + 1)'(FifoDepth));
  assign rd_o.empty = (count_q == '0);
  assign rd_o.data  = mem_q[rptr_q];
  assign do_pop     = pop_i && !rd_o.empty;

  always_comb begin
    count_d = count_q;
    if (wr_i.push && !do_pop) count_d = count_q + 1'b1;
    if (!wr_i.push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i.push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wptr_q] <= wr_i.data;
    end
  end

endmodule

`default_nettype wire

### hdl/tfs_back.sv
// Back end: run fills; an advance within a fill emits one SPI byte.
`default_nettype none

module tfs_back
  import tfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  pix_fmt_e  pixel_format_i,
  input  q_rd_t     q_rd_i,
  output logic      pop_o,
  tfs_byte_if.source byte_o
);

  logic                 busy_q, busy_d;
  logic [HdrIdxW-1:0]   hdr_idx_q, hdr_idx_d;
  logic [PixCountW-1:0] pix_left_q, pix_left_d;
  logic [ChunkW-1:0]    chunk_left_q, chunk_left_d;
  logic [1:0]           bip_q, bip_d;
  logic                 load;
  logic [CoordW-1:0]    cf_q, cl_q, rf_q, rl_q;
  logic [ColorW-1:0]    color_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [7:0]           beat_byte;
  logic                 beat_cmd, beat_eot, beat_last;
  hdr_beat_t            hb;
  logic [1:0]           last_bip;

  assign pop_o = !q_rd_i.empty && (!out_valid_q || byte_o.ready);

  always_comb begin
    busy_d       = busy_q;
    hdr_idx_d    = hdr_idx_q;
    pix_left_d   = pix_left_q;
    chunk_left_d = chunk_left_q;
    bip_d        = bip_q;
    load         = 1'b0;
    out_load     = 1'b0;
    beat_byte    = '0;
    beat_cmd     = 1'b0;
    beat_eot     = 1'b0;
    beat_last    = 1'b0;
    last_bip     = (pixel_format_i == FmtRgb666) ? 2'd2 : 2'd1;
    hb           = header_beat(hdr_idx_q, cf_q, cl_q, rf_q, rl_q);
    if (pop_o) begin
      if (q_rd_i.data.is_start) begin
        // Drop a start that arrives while a fill runs
        if (!busy_q) begin
          load         = 1'b1;
          busy_d       = 1'b1;
          hdr_idx_d    = '0;
          pix_left_d   = q_rd_i.data.pixels;
          chunk_left_d = ChunkW'(ChunkPixels);
          bip_d        = '0;
        end
      end else if (busy_q) begin
        out_load = 1'b1;
        if (hdr_idx_q < HdrIdxW'(HeaderLen)) begin
          beat_byte = hb.data;
          beat_cmd  = hb.is_cmd;
          beat_eot  = hb.eot;
          hdr_idx_d = hdr_idx_q + 1'b1;
        end else begin
          beat_byte = pixel_byte(color_q, pixel_format_i, bip_q);
          if (bip_q >= last_bip) begin
            bip_d = '0;
            if (pix_left_q != '0) pix_left_d = pix_left_q - 1'b1;
            if (chunk_left_q != '0) chunk_left_d = chunk_left_q - 1'b1;
            if (pix_left_d == '0) begin
              beat_eot  = 1'b1;
              beat_last = 1'b1;
              busy_d    = 1'b0;
            end else if (chunk_left_d == '0) begin
              beat_eot     = 1'b1;
              chunk_left_d = ChunkW'(ChunkPixels);
            end
          end else begin
            bip_d = bip_q + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (byte_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      hdr_idx_q    <= '0;
      pix_left_q   <= '0;
      chunk_left_q <= '0;
      bip_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      hdr_idx_q    <= hdr_idx_d;
      pix_left_q   <= pix_left_d;
      chunk_left_q <= chunk_left_d;
      bip_q        <= bip_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cf_q    <= q_rd_i.data.col_first;
      cl_q    <= q_rd_i.data.col_last;
      rf_q    <= q_rd_i.data.row_first;
      rl_q    <= q_rd_i.data.row_last;
      color_q <= q_rd_i.data.color;
    end
    if (out_load) begin
      byte_o.out_byte        <= beat_byte;
      byte_o.is_command      <= beat_cmd;
      byte_o.end_of_transfer <= beat_eot;
      byte_o.last            <= beat_last;
    end
  end

  assign byte_o.valid = out_valid_q;

endmodule

`default_nettype wire

### hdl/tft_rect_fill_streamer.sv
// Top level of the rectangle fill streamer: config registers, front, queue, back.
`default_nettype none

// Usage
//   cmd_i  : command beats. Opcode start carries x, y, w, h and an RGB565
//            color; opcode advance asks for the next SPI byte.
//   byte_o : one beat per advance while a fill runs: the byte, the DC flag
//            (is_command), a chip-select end mark and the last-byte mark.
//   cfg_i  : register writes (0 panel width, 1 panel height, 2 pixel format).
//            Always ready; write only while no command is in flight.
// A fill sends CASET + 4 bytes, PASET + 4 bytes, RAMWR, then w*h pixels of
// two (RGB565) or three (18-bit) bytes; chip select ends after each command,
// each parameter group, every 64 pixels and the final pixel.
// Throughput: one command beat per cycle while the queue has room; one byte
// beat per cycle while advances wait in the queue and the sink is ready. An
// advance beat passes the clip stage and the queue before the output register.
// Reset: the sequencer goes idle, the queue empties and the registers return
// to 240 x 320, RGB565.
// Stall: the output register holds its beat; the 4-entry queue absorbs
// commands until full, then cmd_i.ready drops.

module tft_rect_fill_streamer
  import tfs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tfs_cmd_if.sink    cmd_i,
  tfs_byte_if.source byte_o,
  tfs_cfg_if.sink    cfg_i
);

  logic [CoordW-1:0] panel_width_q, panel_height_q;
  pix_fmt_e          pixel_format_q;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Register file: accept every write, ignore addresses past the list
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= CoordW'(240);
      panel_height_q <= CoordW'(320);
      pixel_format_q <= FmtRgb565;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        CfgPanelWidth:  panel_width_q  <= cfg_i.data;
        CfgPanelHeight: panel_height_q <= cfg_i.data;
        CfgPixelFormat: pixel_format_q <= pix_fmt_e'(cfg_i.data[0]);
        default: ;
      endcase
    end
  end

  // Clip and classify
  tfs_front u_front (
    .clk_i,
    .rst_ni,
    .cmd_i,
    .panel_width_i  (panel_width_q),
    .panel_height_i (panel_height_q),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr)
  );

  // Decouple the front from the byte sequencer
  tfs_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i   (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  // Emit header and pixel bytes
  tfs_back u_back (
    .clk_i,
    .rst_ni,
    .pixel_format_i (pixel_format_q),
    .q_rd_i         (q_rd),
    .pop_o          (q_pop),
    .byte_o
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the rectangle fill streamer: directed table, then random fills.
`default_nettype none

module testbench;
  import tfs_pkg::*;

  localparam int ItemTarget  = 1250;    // useful command beats before the random part stops
  localparam int CycleLimit  = 400000;  // hard stop, many times the slowest legal run
  localparam int MaxIdle     = 12;      // longest gap/stall drawn on either side
  localparam int DrainCycles = 8;       // settle time after the last byte
  localparam int NoiseCap    = 300;     // largest fill a random start may open

  // One command beat as the driver sees it
  typedef struct packed {
    opcode_e            op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [15:0]        color;
  } fill_req_t;

  // One SPI byte beat
  typedef struct packed {
    logic [7:0] data;
    logic       is_cmd;
    logic       eot;
    logic       last;
  } spi_beat_t;

  typedef enum logic {RowCfg, RowCmd} row_kind_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkBeat} chk_e;

  // Directed stimulus row: a register write or a command repeated reps times
  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    reg_idx;
    logic [9:0]  reg_val;
    fill_req_t   req;
    int          reps;
    chk_e        chk;
    spi_beat_t   want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  tfs_cmd_if  cmd_if ();
  tfs_byte_if spi_if ();
  tfs_cfg_if  cfg_if ();

  tft_rect_fill_streamer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .byte_o (spi_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadows and the running fill
  // ---------------------------------------------------------------------------
  logic [9:0]  panel_w = 10'd240;
  logic [9:0]  panel_h = 10'd320;
  pix_fmt_e    pix_fmt = FmtRgb565;

  logic [9:0]  win_col_lo, win_col_hi, win_row_lo, win_row_hi;
  logic [15:0] latched_color;
  logic [3:0]  hdr_pos;
  logic [19:0] px_remaining;
  logic [6:0]  chunk_remaining;
  logic [1:0]  px_byte;
  bit          fill_busy;

  spi_beat_t   spi_beat_q[$];   // bytes still owed by the block, oldest first
  int          fails;
  int          useful_items;    // starts that opened a fill plus advances that emit
  int          cycles;
  bit          quiet;           // no idling on either side while set

  initial begin
    win_col_lo = '0; win_col_hi = '0; win_row_lo = '0; win_row_hi = '0;
    latched_color = '0; hdr_pos = '0; px_remaining = '0; chunk_remaining = '0;
    px_byte = '0; fill_busy = 1'b0;
    fails = 0; useful_items = 0; cycles = 0; quiet = 1'b0;
  end

  // Clip a rectangle to the panel; return the pixel count, zero when it is dropped.
  function automatic int clip_window(input fill_req_t c, output logic [9:0] cf,
                                     output logic [9:0] cl, output logic [9:0] rf,
                                     output logic [9:0] rl);
    int x, y, w, h, pw, ph;
    x = $signed(c.x); y = $signed(c.y);
    w = $signed(c.w); h = $signed(c.h);
    pw = int'(panel_w); ph = int'(panel_h);
    cf = '0; cl = '0; rf = '0; rl = '0;
    if (w <= 0 || h <= 0) return 0;
    if (x >= pw || y >= ph) return 0;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > pw) w = pw - x;
    if (y + h > ph) h = ph - y;
    if (w <= 0 || h <= 0) return 0;
    cf = 10'(x);
    cl = 10'(x + w - 1);
    rf = 10'(y);
    rl = 10'(y + h - 1);
    return w * h;
  endfunction

  // Advance the predictor by one accepted command beat; return 1 when a byte is owed.
  function automatic bit predict_spi_beat(input fill_req_t c, output spi_beat_t r);
    logic [9:0] cf, cl, rf, rl;
    int         px;
    logic [1:0] last_pos;
    r = '0;
    if (c.op == OpStart) begin
      // A start while a fill runs is dropped; so is an empty window.
      if (!fill_busy) begin
        px = clip_window(c, cf, cl, rf, rl);
        if (px > 0) begin
          win_col_lo = cf; win_col_hi = cl; win_row_lo = rf; win_row_hi = rl;
          latched_color = c.color;
          hdr_pos = '0;
          px_remaining = 20'(px);
          chunk_remaining = 7'(ChunkPixels);
          px_byte = '0;
          fill_busy = 1'b1;
        end
      end
      return 1'b0;
    end
    if (!fill_busy) return 1'b0;

    if (hdr_pos < HeaderLen) begin
      // CASET, column pair, PASET, row pair, RAMWR
      case (hdr_pos)
        4'd0: begin
          r.data = CmdColAddrSet; r.is_cmd = 1'b1; r.eot = 1'b1;
        end
        4'd1: r.data = {6'd0, win_col_lo[9:8]};
        4'd2: r.data = win_col_lo[7:0];
        4'd3: r.data = {6'd0, win_col_hi[9:8]};
        4'd4: begin
          r.data = win_col_hi[7:0]; r.eot = 1'b1;
        end
        4'd5: begin
          r.data = CmdPageAddrSet; r.is_cmd = 1'b1; r.eot = 1'b1;
        end
        4'd6: r.data = {6'd0, win_row_lo[9:8]};
        4'd7: r.data = win_row_lo[7:0];
        4'd8: r.data = {6'd0, win_row_hi[9:8]};
        4'd9: begin
          r.data = win_row_hi[7:0]; r.eot = 1'b1;
        end
        default: begin
          r.data = CmdMemWrite; r.is_cmd = 1'b1; r.eot = 1'b1;
        end
      endcase
      hdr_pos = hdr_pos + 4'd1;
    end else begin
      // The format is read per byte, so a change mid-pixel takes effect at once.
      last_pos = (pix_fmt == FmtRgb666) ? 2'd2 : 2'd1;
      if (pix_fmt == FmtRgb565) begin
        r.data = (px_byte == 2'd0) ? latched_color[15:8] : latched_color[7:0];
      end else if (px_byte == 2'd0) begin
        r.data = 8'(latched_color >> 8) & Mask5;
      end else if (px_byte == 2'd1) begin
        r.data = 8'(latched_color >> 3) & Mask6;
      end else begin
        r.data = 8'(latched_color << 3) & Mask5;
      end
      if (px_byte >= last_pos) begin
        px_byte = '0;
        if (px_remaining > 0) px_remaining = px_remaining - 20'd1;
        if (chunk_remaining > 0) chunk_remaining = chunk_remaining - 7'd1;
        if (px_remaining == 0) begin
          r.eot = 1'b1;
          r.last = 1'b1;
          fill_busy = 1'b0;
        end else if (chunk_remaining == 0) begin
          r.eot = 1'b1;
          chunk_remaining = 7'(ChunkPixels);
        end
      end else begin
        px_byte = px_byte + 2'd1;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Drive one command beat, hold it until accepted, then step the predictor.
  task automatic put_cmd(input fill_req_t c, output bit got, output spi_beat_t r);
    int gap;
    bit hit;
    bit was_busy;
    gap = quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= c.op;
    cmd_if.rect_x     <= c.x;
    cmd_if.rect_y     <= c.y;
    cmd_if.rect_w     <= c.w;
    cmd_if.rect_h     <= c.h;
    cmd_if.fill_color <= c.color;
    // Sample ready mid-cycle: it is stable there and holds through the next edge.
    do begin
      @(negedge clk_i);
      hit = cmd_if.ready;
      @(posedge clk_i);
    end while (!hit);
    was_busy = fill_busy;
    got = predict_spi_beat(c, r);
    if (got || (!was_busy && fill_busy)) useful_items++;
  endtask

  // Drive a command and queue whatever byte the predictor owes for it.
  task automatic send(input fill_req_t c);
    bit        got;
    spi_beat_t r;
    put_cmd(c, got, r);
    if (got) spi_beat_q.push_back(r);
  endtask

  // Write one register once every owed byte is out and the pipeline has settled.
  task automatic write_reg(input cfg_idx_e idx, input logic [9:0] val);
    bit hit;
    cmd_if.valid <= 1'b0;
    while (spi_beat_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk_i);
      hit = cfg_if.ready;
      @(posedge clk_i);
    end while (!hit);
    cfg_if.valid <= 1'b0;
    case (idx)
      CfgPanelWidth:  panel_w = val;
      CfgPanelHeight: panel_h = val;
      default:        pix_fmt = pix_fmt_e'(val[0]);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus shapes
  // ---------------------------------------------------------------------------

  // Advance beat: the rectangle fields are don't-care, so fill them with noise.
  function automatic fill_req_t rand_advance();
    fill_req_t c;
    c.op = OpAdvance;
    c.x = 16'($urandom); c.y = 16'($urandom);
    c.w = 16'($urandom); c.h = 16'($urandom);
    c.color = 16'($urandom);
    return c;
  endfunction

  // Start with raw random fields; sink it when it would open a huge fill.
  function automatic fill_req_t rand_start();
    fill_req_t  c;
    logic [9:0] a, b, d, e;
    c = rand_advance();
    c.op = OpStart;
    if (!fill_busy && clip_window(c, a, b, d, e) > NoiseCap) c.w[15] = 1'b1;
    return c;
  endfunction

  // Pick an edge for a span of len pixels: inside, across either border, or outside.
  function automatic int place(input int extent, input int len);
    case ($urandom_range(0, 4))
      0, 1:    return int'($urandom_range(0, (extent > 0) ? extent - 1 : 0));
      2:       return -int'($urandom_range(0, len - 1));
      3:       return extent - int'($urandom_range(1, len));
      default: return $urandom_range(0, 1) ? extent + int'($urandom_range(0, 3))
                                           : -len - int'($urandom_range(0, 3));
    endcase
  endfunction

  // Well-formed start: small windows mostly, now and then one that spans chunks.
  function automatic fill_req_t shaped_start();
    fill_req_t c;
    int        w, h;
    bit        big;
    big = ($urandom_range(0, 7) == 0);
    w = big ? $urandom_range(9, 13) : $urandom_range(1, 6);
    h = big ? $urandom_range(7, 10) : $urandom_range(1, 6);
    c.op = OpStart;
    c.x = 16'(place(int'(panel_w), w));
    c.y = 16'(place(int'(panel_h), h));
    c.w = 16'(w);
    c.h = 16'(h);
    // Overlong width pinned at the right border: clipping trims it to a few columns.
    if ($urandom_range(0, 9) == 0) begin
      c.x = 16'(int'(panel_w) - int'($urandom_range(1, 4)));
      c.w = 16'sh7FFF;
    end
    c.color = 16'($urandom);
    return c;
  endfunction

  function automatic logic [9:0] pick_extent();
    case ($urandom_range(0, 11))
      0:       return 10'd0;
      1, 2:    return 10'd1023;
      3, 4:    return 10'd1;
      5, 6, 7: return 10'($urandom_range(1, 20));
      default: return 10'($urandom_range(1, 1023));
    endcase
  endfunction

  // One fill: a start, advances until it ends, with the odd stray start or
  // register change folded in, then a few advances into an idle block.
  task automatic run_fill();
    fill_req_t c;
    int        k, stray_at, reg_at;
    c = ($urandom_range(0, 6) == 0) ? rand_start() : shaped_start();
    send(c);
    k = 0;
    stray_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : -1;
    reg_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : -1;
    while (fill_busy) begin
      if (k == stray_at) send(rand_start());
      if (k == reg_at) begin
        case ($urandom_range(0, 2))
          0:       write_reg(CfgPixelFormat, (pix_fmt == FmtRgb565) ? 10'd1 : 10'd0);
          1:       write_reg(CfgPanelWidth, pick_extent());
          default: write_reg(CfgPanelHeight, pick_extent());
        endcase
      end
      send(rand_advance());
      k++;
    end
    repeat ($urandom_range(0, 2)) send(rand_advance());
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab[$];

  task automatic tab_cfg(input cfg_idx_e idx, input int v);
    dir_row_t row;
    row = '{kind: RowCfg, reg_idx: idx, reg_val: 10'(v), req: '0, reps: 1,
            chk: ChkNone, want: '0};
    dir_tab.push_back(row);
  endtask

  task automatic tab_start(input int x, input int y, input int w, input int h,
                           input int color);
    dir_row_t row;
    row = '{kind: RowCmd, reg_idx: CfgPanelWidth, reg_val: '0, req: '0, reps: 1,
            chk: ChkNone, want: '0};
    row.req.op = OpStart;
    row.req.x = 16'(x); row.req.y = 16'(y);
    row.req.w = 16'(w); row.req.h = 16'(h);
    row.req.color = 16'(color);
    dir_tab.push_back(row);
  endtask

  // Advances checked against the predictor
  task automatic tab_adv(input int reps);
    dir_row_t row;
    row = '{kind: RowCmd, reg_idx: CfgPanelWidth, reg_val: '0, req: '0, reps: reps,
            chk: ChkModel, want: '0};
    row.req.op = OpAdvance;
    dir_tab.push_back(row);
  endtask

  // Advance into an idle block: nothing comes out
  task automatic tab_idle_adv();
    dir_row_t row;
    row = '{kind: RowCmd, reg_idx: CfgPanelWidth, reg_val: '0, req: '0, reps: 1,
            chk: ChkNone, want: '0};
    row.req.op = OpAdvance;
    row.req.x = 16'sh7FFF; row.req.w = 16'sh8000;
    dir_tab.push_back(row);
  endtask

  // Advance with its byte typed in
  task automatic tab_beat(input logic [7:0] b, input bit is_cmd, input bit eot,
                          input bit last);
    dir_row_t row;
    row = '{kind: RowCmd, reg_idx: CfgPanelWidth, reg_val: '0, req: '0, reps: 1,
            chk: ChkBeat, want: '0};
    row.req.op = OpAdvance;
    row.want = '{data: b, is_cmd: is_cmd, eot: eot, last: last};
    dir_tab.push_back(row);
  endtask

  task automatic build_table();
    // Out of reset: 240 x 320, RGB565, idle
    tab_idle_adv();
    tab_start(-32768, -32768, 32767, 32767, 'hFFFF);  // clips to nothing
    tab_idle_adv();
    // Huge window anchored at the bottom-right pixel clips to 1 x 1
    tab_start(239, 319, 32767, 32767, 'hF81F);
    tab_beat(CmdColAddrSet,  1, 1, 0);
    tab_beat(8'h00,          0, 0, 0);
    tab_beat(8'hEF,          0, 0, 0);
    tab_beat(8'h00,          0, 0, 0);
    tab_beat(8'hEF,          0, 1, 0);
    tab_beat(CmdPageAddrSet, 1, 1, 0);
    tab_beat(8'h01,          0, 0, 0);
    tab_beat(8'h3F,          0, 0, 0);
    tab_beat(8'h01,          0, 0, 0);
    tab_beat(8'h3F,          0, 1, 0);
    tab_beat(CmdMemWrite,    1, 1, 0);
    tab_start(0, 0, 5, 5, 'h1234);                    // busy: dropped
    tab_beat(8'hF8,          0, 0, 0);
    tab_beat(8'h1F,          0, 1, 1);
    tab_idle_adv();
    // 18-bit pixels, window hanging off the top-left corner
    tab_cfg(CfgPixelFormat, 1);
    tab_start(-5, -3, 6, 4, 'hFFFF);
    tab_adv(14);
    // Switch format on the third byte of a pixel, then resize the panel mid-fill
    tab_start(0, 0, 2, 1, 'hA5C3);
    tab_adv(13);
    tab_cfg(CfgPixelFormat, 0);
    tab_adv(1);
    tab_cfg(CfgPanelWidth, 16);
    tab_adv(2);
    // Zero-width panel drops everything
    tab_cfg(CfgPanelWidth, 0);
    tab_start(0, 0, 1, 1, 'h0000);
    tab_idle_adv();
    // Largest panel, window at the far corner: address high bytes are nonzero
    tab_cfg(CfgPanelWidth, 1023);
    tab_cfg(CfgPanelHeight, 1023);
    tab_start(1020, 1020, 32767, 32767, 'h0000);
    tab_adv(29);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the byte sink
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Byte sink: stall a random number of cycles before each beat, then take it.
  initial begin
    int n;
    bit hit;
    spi_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n = quiet ? 0 : $urandom_range(0, MaxIdle);
      if (n > 0) begin
        spi_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      spi_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        hit = spi_if.valid;
        @(posedge clk_i);
      end while (!hit);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Byte monitor: every accepted beat must match the oldest owed byte.
  always @(posedge clk_i) begin : byte_mon
    spi_beat_t got, want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t: timeout, %0d bytes still owed", $time, spi_beat_q.size());
        $display("testbench: FAIL");
        $finish;
      end
      if (spi_if.valid && spi_if.ready) begin
        got = '{data: spi_if.out_byte, is_cmd: spi_if.is_command,
                eot: spi_if.end_of_transfer, last: spi_if.last};
        if (spi_beat_q.size() == 0) begin
          $display("%0t: unexpected byte beat, expected none, got %02h cmd=%b eot=%b last=%b",
                   $time, got.data, got.is_cmd, got.eot, got.last);
          fails++;
        end else begin
          want = spi_beat_q.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("is_command", want.is_cmd, got.is_cmd);
          check_field("end_of_transfer", want.eot, got.eot);
          check_field("last", want.last, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    dir_row_t  row;
    bit        got;
    spi_beat_t r;
    int        phase;

    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = OpAdvance;
    cmd_if.rect_x = '0; cmd_if.rect_y = '0;
    cmd_if.rect_w = '0; cmd_if.rect_h = '0;
    cmd_if.fill_color = '0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = CfgPanelWidth;
    cfg_if.data = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; typed rows override the predictor's answer.
    build_table();
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == RowCfg) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        repeat (row.reps) begin
          put_cmd(row.req, got, r);
          case (row.chk)
            ChkModel: if (got) spi_beat_q.push_back(r);
            ChkBeat:  spi_beat_q.push_back(row.want);
            default:  ;
          endcase
        end
      end
    end

    // Random phases: set the panel, then a batch of fills. The first two
    // phases pin the panel extremes; after that sizes and format are drawn.
    phase = 0;
    while (useful_items < ItemTarget) begin
      case (phase)
        0: begin
          write_reg(CfgPanelWidth, 10'd1023);
          write_reg(CfgPanelHeight, 10'd1023);
          write_reg(CfgPixelFormat, 10'd1);
        end
        1: begin
          write_reg(CfgPanelWidth, 10'd1);
          write_reg(CfgPanelHeight, 10'd1);
          write_reg(CfgPixelFormat, 10'd0);
        end
        default: begin
          write_reg(CfgPanelWidth, pick_extent());
          write_reg(CfgPanelHeight, pick_extent());
          write_reg(CfgPixelFormat, 10'($urandom_range(0, 1)));
        end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      // Stop at the fill that reaches the target rather than at the end of the batch.
      repeat (8) if (useful_items < ItemTarget) run_fill();
      phase++;
    end
    quiet = 1'b0;

    // Drop valid, let every owed byte out, then give the pipeline time to
    // show any stray beat.
    cmd_if.valid <= 1'b0;
    while (spi_beat_q.size() != 0) @(posedge clk_i);
    repeat (4 * DrainCycles) @(posedge clk_i);

    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
